/* rtl/pct_pkg.sv */
`default_nettype none

package pct_pkg;

    // store and coordinate sizes
    localparam int MAX_VERTICES = 256;
    localparam int ADDR_W      = $clog2(MAX_VERTICES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int COORD_WIDTH = 32;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;

    // operation codes
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TEST   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // request payload
    typedef struct packed {
        logic [1:0]        operation;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } req_t;

    // response payload
    typedef struct packed {
        logic       inside_res;
        logic       status;
        logic [8:0] vertices_held;
    } rsp_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_DRAIN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              append;
        logic              clear;
        logic              imm_res;
        logic              start;
        logic              rd_en;
        logic              rd_edge;
        logic [ADDR_W-1:0] rd_addr;
        logic              fin_res;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
        logic             out_free;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/pct_ctrl.sv */
`default_nettype none

module pct_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic [1:0]    req_op,
    output logic               req_stall,
    input  wire pct_pkg::sts_t sts,
    output pct_pkg::cmd_t      cmd
);

    pct_pkg::state_t                state_reg;
    pct_pkg::state_t                state_next;
    logic [pct_pkg::ADDR_W-1:0]     idx_reg;
    logic [pct_pkg::ADDR_W-1:0]     idx_next;
    logic [pct_pkg::CNT_W-1:0]      count_m1;
    logic [pct_pkg::ADDR_W-1:0]     last_addr;
    logic                           ready;
    logic                           accept;
    pct_pkg::op_t                   op;

    // request handshake
    assign ready     = (state_reg == pct_pkg::ST_IDLE) && sts.out_free;
    assign req_stall = !ready;
    assign accept    = req_valid && ready;
    assign op        = pct_pkg::op_t'(req_op);
    assign count_m1  = sts.count - pct_pkg::CNT_W'(1);
    assign last_addr = count_m1[pct_pkg::ADDR_W-1:0];

    // state and edge index registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pct_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            pct_pkg::ST_IDLE:
            begin
                if (accept && op == pct_pkg::OP_TEST && sts.count != '0)
                begin
                    state_next = pct_pkg::ST_LOAD;
                end
            end
            pct_pkg::ST_LOAD:
            begin
                idx_next   = '0;
                state_next = pct_pkg::ST_WALK;
            end
            pct_pkg::ST_WALK:
            begin
                if (idx_reg == last_addr)
                begin
                    state_next = pct_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + pct_pkg::ADDR_W'(1);
                end
            end
            pct_pkg::ST_DRAIN:
            begin
                if (!sts.busy && sts.out_free)
                begin
                    state_next = pct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pct_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            pct_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        pct_pkg::OP_APPEND:
                        begin
                            cmd.append  = 1'b1;
                            cmd.imm_res = 1'b1;
                        end
                        pct_pkg::OP_TEST:
                        begin
                            if (sts.count == '0)
                            begin
                                cmd.imm_res = 1'b1;
                            end
                            else
                            begin
                                cmd.start = 1'b1;
                            end
                        end
                        pct_pkg::OP_CLEAR:
                        begin
                            cmd.clear   = 1'b1;
                            cmd.imm_res = 1'b1;
                        end
                        pct_pkg::OP_NONE:
                        begin
                            cmd.imm_res = 1'b1;
                        end
                        default:
                        begin
                            cmd.imm_res = 1'b1;
                        end
                    endcase
                end
            end
            pct_pkg::ST_LOAD:
            begin
                // preload the closing vertex as the first previous vertex
                cmd.rd_en   = 1'b1;
                cmd.rd_edge = 1'b0;
                cmd.rd_addr = last_addr;
            end
            pct_pkg::ST_WALK:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_edge = 1'b1;
                cmd.rd_addr = idx_reg;
            end
            pct_pkg::ST_DRAIN:
            begin
                cmd.fin_res = !sts.busy && sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/pct_dp.sv */
`default_nettype none

module pct_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pct_pkg::req_t req_data,
    input  wire pct_pkg::cmd_t cmd,
    output pct_pkg::sts_t      sts,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output pct_pkg::rsp_t      rsp_data
);

    // vertex store
    logic [pct_pkg::COORD_WIDTH-1:0] x_mem [pct_pkg::MAX_VERTICES];
    logic [pct_pkg::COORD_WIDTH-1:0] y_mem [pct_pkg::MAX_VERTICES];

    logic [pct_pkg::CNT_W-1:0]       count_reg;
    logic [pct_pkg::CNT_W-1:0]       count_next;
    logic                            full;

    logic signed [pct_pkg::COORD_WIDTH-1:0] tx_reg;
    logic signed [pct_pkg::COORD_WIDTH-1:0] ty_reg;

    // stage 1: read data
    logic                                   s1_v_reg;
    logic                                   s1_edge_reg;
    logic signed [pct_pkg::COORD_WIDTH-1:0] rd_x_reg;
    logic signed [pct_pkg::COORD_WIDTH-1:0] rd_y_reg;
    logic signed [pct_pkg::COORD_WIDTH-1:0] prev_x_reg;
    logic signed [pct_pkg::COORD_WIDTH-1:0] prev_y_reg;

    // stage 2: differences
    logic                              s2_v_reg;
    logic                              s2_strad_reg;
    logic signed [pct_pkg::DIFF_W-1:0] dtx_reg;
    logic signed [pct_pkg::DIFF_W-1:0] dy_reg;
    logic signed [pct_pkg::DIFF_W-1:0] dx_reg;
    logic signed [pct_pkg::DIFF_W-1:0] dty_reg;
    logic signed [pct_pkg::DIFF_W-1:0] dtx_c;
    logic signed [pct_pkg::DIFF_W-1:0] dy_c;
    logic signed [pct_pkg::DIFF_W-1:0] dx_c;
    logic signed [pct_pkg::DIFF_W-1:0] dty_c;
    logic                              strad_c;

    // stage 3: products
    logic                              s3_v_reg;
    logic                              s3_strad_reg;
    logic                              s3_dneg_reg;
    logic signed [pct_pkg::PROD_W-1:0] lhs_reg;
    logic signed [pct_pkg::PROD_W-1:0] rhs_reg;
    logic                              left_c;

    logic                              parity_reg;
    logic                              out_valid_reg;
    pct_pkg::rsp_t                     out_reg;
    logic                              out_free;

    assign full       = (count_reg == pct_pkg::CNT_W'(pct_pkg::MAX_VERTICES));
    assign out_free   = !out_valid_reg || !rsp_stall;
    assign sts.count    = count_reg;
    assign sts.busy     = s1_v_reg || s2_v_reg || s3_v_reg;
    assign sts.out_free = out_free;
    assign rsp_valid  = out_valid_reg;
    assign rsp_data   = out_reg;

    // vertex count after this request
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append && !full)
        begin
            count_next = count_reg + pct_pkg::CNT_W'(1);
        end
    end

    // store write and read port
    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            x_mem[count_reg[pct_pkg::ADDR_W-1:0]] <= req_data.coord_x;
            y_mem[count_reg[pct_pkg::ADDR_W-1:0]] <= req_data.coord_y;
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= x_mem[cmd.rd_addr];
            rd_y_reg <= y_mem[cmd.rd_addr];
        end
    end

    // edge setup: straddle test and differences
    always_comb
    begin
        strad_c = (ty_reg < rd_y_reg) ^ (ty_reg < prev_y_reg);
        dtx_c   = pct_pkg::DIFF_W'(tx_reg) - pct_pkg::DIFF_W'(rd_x_reg);
        dy_c    = pct_pkg::DIFF_W'(prev_y_reg) - pct_pkg::DIFF_W'(rd_y_reg);
        dx_c    = pct_pkg::DIFF_W'(prev_x_reg) - pct_pkg::DIFF_W'(rd_x_reg);
        dty_c   = pct_pkg::DIFF_W'(ty_reg) - pct_pkg::DIFF_W'(rd_y_reg);
    end

    // crossing side, flipped for an edge rising from the previous vertex
    assign left_c = s3_dneg_reg ? (rhs_reg < lhs_reg) : (lhs_reg < rhs_reg);

    // payload pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            tx_reg <= req_data.coord_x;
            ty_reg <= req_data.coord_y;
        end
        if (s1_v_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        dtx_reg      <= dtx_c;
        dy_reg       <= dy_c;
        dx_reg       <= dx_c;
        dty_reg      <= dty_c;
        s2_strad_reg <= strad_c;
        lhs_reg      <= pct_pkg::PROD_W'(dtx_reg) * pct_pkg::PROD_W'(dy_reg);
        rhs_reg      <= pct_pkg::PROD_W'(dx_reg) * pct_pkg::PROD_W'(dty_reg);
        s3_dneg_reg  <= dy_reg[pct_pkg::DIFF_W-1];
        s3_strad_reg <= s2_strad_reg;
    end

    // control: count, pipeline valids, parity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            s1_v_reg    <= 1'b0;
            s1_edge_reg <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            parity_reg  <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            s1_v_reg    <= cmd.rd_en;
            s1_edge_reg <= cmd.rd_edge;
            s2_v_reg    <= s1_v_reg && s1_edge_reg;
            s3_v_reg    <= s2_v_reg;
            if (cmd.start)
            begin
                parity_reg <= 1'b0;
            end
            else if (s3_v_reg && s3_strad_reg && left_c)
            begin
                parity_reg <= !parity_reg;
            end
        end
    end

    // response register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.imm_res || cmd.fin_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // response register payload
    always_ff @(posedge clk)
    begin
        if (cmd.imm_res)
        begin
            out_reg.inside_res    <= 1'b0;
            out_reg.status        <= cmd.append && full;
            out_reg.vertices_held <= count_next;
        end
        else if (cmd.fin_res)
        begin
            out_reg.inside_res    <= parity_reg;
            out_reg.status        <= 1'b0;
            out_reg.vertices_held <= count_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/polygon_crossing_test.sv */
// Point-in-polygon test by crossing parity over a stored vertex list.
// Request channel (req_valid, req_stall, req_data) carries an operation and
// one Q16.16 point: append a vertex, test the point, or clear the polygon.
// Response channel (rsp_valid, rsp_stall, rsp_data) returns one response per
// request: inside flag, store-full drop flag and the vertex count afterwards.
// Append, clear and empty-polygon tests answer in the cycle after accept.
// A test on n vertices reads the closing vertex, then one vertex per cycle
// through the single read port of the store, then drains a four-stage edge
// pipeline (read, differences, products, compare) into the response register.
// Up to 256 vertices; an append to a full store is dropped with status set.
// One request is in flight at a time; the next one is taken as soon as the
// response register is free, even while a response is being delivered.
// Reset empties the polygon and drops any pending response; stored vertex
// data is not cleared. While the receiver stalls a response, the response
// holds and no new request is accepted.
`default_nettype none

module polygon_crossing_test (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire pct_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output pct_pkg::rsp_t      rsp_data
);

    pct_pkg::cmd_t cmd;
    pct_pkg::sts_t sts;

    // sequencer
    pct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req_data.operation),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // vertex store and edge pipeline
    pct_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEMS     = 850;
    localparam int          LONG_HOLD = 250;
    localparam int unsigned LIMIT     = 1_500_000;
    localparam int          CMIN      = 32'h8000_0000;
    localparam int          CMAX      = 32'h7fff_ffff;
    localparam int          ONE       = 32'h0001_0000;

    // crossing parity predictor and queue of expected responses
    class crossing_scoreboard;
        int            xs[pct_pkg::MAX_VERTICES];
        int            ys[pct_pkg::MAX_VERTICES];
        int unsigned   held;
        pct_pkg::rsp_t expected_q[$];
        int            errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        // parity of edge crossings left of the point, exact wide products
        function bit point_inside(int tx, int ty);
            bit                 parity;
            bit                 ai;
            bit                 aj;
            bit                 left;
            int unsigned        j;
            longint             d;
            logic signed [67:0] d_w;
            logic signed [67:0] dtx_w;
            logic signed [67:0] dxe_w;
            logic signed [67:0] dty_w;
            logic signed [67:0] lhs;
            logic signed [67:0] rhs;
            parity = 1'b0;
            if (held == 0)
                return 1'b0;
            j = held - 1;
            for (int unsigned i = 0; i < held; i++)
            begin
                ai = ty < ys[i];
                aj = ty < ys[j];
                if (ai != aj)
                begin
                    d     = longint'(ys[j]) - longint'(ys[i]);
                    d_w   = d;
                    dtx_w = longint'(tx) - longint'(xs[i]);
                    dxe_w = longint'(xs[j]) - longint'(xs[i]);
                    dty_w = longint'(ty) - longint'(ys[i]);
                    lhs   = dtx_w * d_w;
                    rhs   = dxe_w * dty_w;
                    left  = (d > 0) ? (lhs < rhs) : (rhs < lhs);
                    if (left)
                        parity = !parity;
                end
                j = i;
            end
            return parity;
        endfunction

        // accepted request: update the polygon and queue its response
        function void note_request(pct_pkg::req_t r);
            pct_pkg::rsp_t e;
            e = '0;
            case (pct_pkg::op_t'(r.operation))
                pct_pkg::OP_APPEND:
                begin
                    if (held < pct_pkg::MAX_VERTICES)
                    begin
                        xs[held] = r.coord_x;
                        ys[held] = r.coord_y;
                        held++;
                    end
                    else
                        e.status = 1'b1;
                end
                pct_pkg::OP_TEST:  e.inside_res = point_inside(r.coord_x, r.coord_y);
                pct_pkg::OP_CLEAR: held = 0;
                default:  ;
            endcase
            e.vertices_held = 9'(held);
            expected_q.push_back(e);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        endfunction

        // delivered response against the oldest expectation
        function void check_response(pct_pkg::rsp_t got);
            pct_pkg::rsp_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response %p", $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.inside_res !== want.inside_res)
                report("inside_res", want.inside_res, got.inside_res);
            if (got.status !== want.status)
                report("status", want.status, got.status);
            if (got.vertices_held !== want.vertices_held)
                report("vertices_held", want.vertices_held, got.vertices_held);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    pct_pkg::req_t req_data  = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    pct_pkg::rsp_t rsp_data;

    crossing_scoreboard sb = new();

    bit          tx_steady    = 1'b0;
    bit          rx_steady    = 1'b0;
    bit          hold_request = 1'b0;
    int          sent         = 0;
    int unsigned cycle_count  = 0;

    polygon_crossing_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp_data);
    end

    // mostly short idle gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stall pattern, with one long hold when asked
    initial
    begin
        int unsigned r;
        int unsigned len;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (rx_steady)
                rsp_stall <= 1'b0;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    rsp_stall <= 1'b0;
                    len = $urandom_range(1, 8);
                end
                else if (r < 92)
                begin
                    rsp_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    rsp_stall <= 1'b1;
                    len = $urandom_range(10, 40);
                end
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    function automatic pct_pkg::req_t make_req(pct_pkg::op_t op, int x, int y);
        pct_pkg::req_t r;
        r.operation = op;
        r.coord_x   = x;
        r.coord_y   = y;
        return r;
    endfunction

    // coordinate scaled down by an arithmetic shift
    function automatic int rand_coord(int unsigned sh);
        int v;
        v = $urandom;
        return v >>> sh;
    endfunction

    // offer one request and hold it until accepted
    task automatic send_request(pct_pkg::req_t r);
        int unsigned gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(r);
        sent++;
    endtask

    // withdraw the request and wait until every response is back
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // random noise request: any operation, full-range coordinates
    task automatic send_noise();
        send_request(make_req(pct_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom));
    endtask

    // usually clear, then build a polygon and test points around it
    task automatic polygon_round(bit fill);
        int unsigned r;
        int unsigned sh;
        int unsigned n;
        int unsigned tests;
        int          x;
        int          y;
        int          vxs[$];
        int          vys[$];
        r  = $urandom_range(0, 99);
        sh = (r < 15) ? 0 : $urandom_range(12, 30);
        if (fill)
            n = pct_pkg::MAX_VERTICES + 3;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                n = 0;
            else if (r < 92)
                n = $urandom_range(1, 12);
            else
                n = $urandom_range(13, 60);
        end
        if (fill || $urandom_range(0, 9) != 0)
            send_request(make_req(pct_pkg::OP_CLEAR, rand_coord(0), rand_coord(0)));
        for (int unsigned k = 0; k < n; k++)
        begin
            x = rand_coord(sh);
            y = rand_coord(sh);
            // repeated y gives horizontal edges
            if (vys.size() > 0 && $urandom_range(0, 9) == 0)
                y = vys[vys.size() - 1];
            vxs.push_back(x);
            vys.push_back(y);
            send_request(make_req(pct_pkg::OP_APPEND, x, y));
            if ($urandom_range(0, 19) == 0)
                send_noise();
        end
        tests = fill ? 4 : $urandom_range(1, 6);
        repeat (tests)
        begin
            x = rand_coord(sh);
            y = rand_coord(sh);
            // points level with a vertex hit the straddle boundary
            if (vys.size() > 0 && $urandom_range(0, 3) == 0)
                y = vys[$urandom_range(0, vys.size() - 1)];
            if (vxs.size() > 0 && $urandom_range(0, 6) == 0)
                x = vxs[$urandom_range(0, vxs.size() - 1)];
            send_request(make_req(pct_pkg::OP_TEST, x, y));
        end
        if ($urandom_range(0, 11) == 0)
            send_request(make_req(pct_pkg::OP_NONE, $urandom, $urandom));
    endtask

    initial
    begin
        int round_no;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, one vertex, horizontal pair, extreme triangle, quad, clear
        send_request(make_req(pct_pkg::OP_TEST, 0, 0));
        send_request(make_req(pct_pkg::OP_NONE, CMAX, CMIN));
        send_request(make_req(pct_pkg::OP_APPEND, 0, 0));
        send_request(make_req(pct_pkg::OP_TEST, 0, 0));
        send_request(make_req(pct_pkg::OP_APPEND, 4 * ONE, 0));
        send_request(make_req(pct_pkg::OP_TEST, ONE, 0));
        send_request(make_req(pct_pkg::OP_CLEAR, CMAX, CMAX));
        send_request(make_req(pct_pkg::OP_APPEND, CMIN, CMIN));
        send_request(make_req(pct_pkg::OP_APPEND, CMAX, CMIN));
        send_request(make_req(pct_pkg::OP_APPEND, 0, CMAX));
        send_request(make_req(pct_pkg::OP_TEST, 0, 0));
        send_request(make_req(pct_pkg::OP_TEST, CMAX, CMAX));
        send_request(make_req(pct_pkg::OP_TEST, CMIN, 0));
        send_request(make_req(pct_pkg::OP_TEST, 0, CMIN));
        send_request(make_req(pct_pkg::OP_TEST, -1, CMIN + 1));
        send_request(make_req(pct_pkg::OP_TEST, CMAX - 1, CMIN + 1));
        send_request(make_req(pct_pkg::OP_NONE, CMIN, CMAX));
        send_request(make_req(pct_pkg::OP_APPEND, CMIN, CMAX));
        send_request(make_req(pct_pkg::OP_TEST, CMIN + 1, 0));
        send_request(make_req(pct_pkg::OP_TEST, CMIN, CMAX - 1));
        send_request(make_req(pct_pkg::OP_CLEAR, 0, 0));
        send_request(make_req(pct_pkg::OP_TEST, ONE, ONE));

        // sender pauses until every response is back
        wait_for_results();

        // random polygons with pressure phases mixed in
        round_no = 0;
        while (sent < ITEMS)
        begin
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            if (round_no == 3 || round_no == 14)
            begin
                // long receiver hold while requests keep coming
                hold_request = 1'b1;
                tx_steady    = 1'b1;
            end
            if (round_no == 9)
                wait_for_results();
            if (round_no == 16 || round_no == 17)
            begin
                tx_steady = 1'b1;
                rx_steady = 1'b1;
            end
            polygon_round(round_no == 6);
            round_no++;
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/pct_pkg.sv
rtl/pct_ctrl.sv
rtl/pct_dp.sv
rtl/polygon_crossing_test.sv
test/tb.sv
